// File: rtl/core/i2c_master_byte_engine_assert.svh
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_assert.svh
// Assertion macros used by the I2C master byte engine sequencer.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define I2CM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

   localparam int unsigned CMD_W    = 3;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned QDEPTH   = 2;
   localparam int unsigned QPTR_W   = $clog2(QDEPTH);
   localparam int unsigned QCNT_W   = QPTR_W + 1;

   // command codes as seen on the request channel
   localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

   // register indexes of the csr port
   localparam logic CSR_DELAY_TICKS = 1'b0;
   localparam logic CSR_ACK_TIMEOUT = 1'b1;

   localparam logic [BYTE_W-1:0] DELAY_TICKS_RST = 8'd20;
   localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST = 8'd250;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_START,
      KIND_STOP,
      KIND_WRITE,
      KIND_READ
   } kind_type;

   // one classified tick as it sits in the queue
   typedef struct packed {
      kind_type           kind;
      logic [BYTE_W-1:0]  tx_byte;
      logic               send_ack;
      logic               sda_in;
   } tick_type;

endpackage

`default_nettype wire

// File: rtl/core/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Takes request ticks, classifies the command and hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [i2cm_pkg::CMD_W-1:0] req_cmd,
   input  wire logic [i2cm_pkg::BYTE_W-1:0] req_tx_byte,
   input  wire logic                   req_send_ack,
   input  wire logic                   req_sda_in,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output i2cm_pkg::tick_type          push_tick
);

   logic               vld_ff, vld_in;
   i2cm_pkg::tick_type tick_ff, tick_in;
   i2cm_pkg::kind_type kind;
   logic               take;

   always_comb begin
      unique case (req_cmd)
         i2cm_pkg::CMD_START: kind = i2cm_pkg::KIND_START;
         i2cm_pkg::CMD_STOP:  kind = i2cm_pkg::KIND_STOP;
         i2cm_pkg::CMD_WRITE: kind = i2cm_pkg::KIND_WRITE;
         i2cm_pkg::CMD_READ:  kind = i2cm_pkg::KIND_READ;
         default:             kind = i2cm_pkg::KIND_NONE;
      endcase
   end

   assign req_tready = !vld_ff || push_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      tick_in = tick_ff;
      vld_in  = vld_ff && !push_ready;
      if (take) begin
         vld_in           = 1'b1;
         tick_in.kind     = kind;
         tick_in.tx_byte  = req_tx_byte;
         tick_in.send_ack = req_send_ack;
         tick_in.sda_in   = req_sda_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      tick_ff <= tick_in;
   end

   assign push_valid = vld_ff;
   assign push_tick  = tick_ff;

endmodule

`default_nettype wire

// File: rtl/core/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue
// Short FIFO of classified ticks between the front and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire i2cm_pkg::tick_type push_tick,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output i2cm_pkg::tick_type      pop_tick
);

   i2cm_pkg::tick_type                  slot_ff [i2cm_pkg::QDEPTH];
   logic [i2cm_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [i2cm_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [i2cm_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                                push, pop;

   assign push_ready = count_ff != i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_tick   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_tick;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Line sequencer: advances one tick per queued item, drives the result reg.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_byte_engine_assert.svh"

module i2cm_seq (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_valid,
   input  wire logic                        csr_index,
   input  wire logic [i2cm_pkg::BYTE_W-1:0] csr_data,
   input  wire logic                        pop_valid,
   output logic                             pop_ready,
   input  wire i2cm_pkg::tick_type          pop_tick,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [15:0]                      rsp_tdata
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_SP_C,
      PH_WR_LOW, PH_WR_HIGH, PH_WR_TAIL, PH_ACK_REL, PH_ACK_HIGH, PH_ACK_POLL,
      PH_RD_LOW, PH_RD_HIGH, PH_MA_SET, PH_MA_CLK
   } phase_type;

   localparam int unsigned BW = i2cm_pkg::BYTE_W;

   phase_type     phase_ff, phase_in;
   logic [3:0]    bit_ff, bit_in, bit_next;
   logic [BW-1:0] shift_ff, shift_in;
   logic [BW-1:0] delay_ff, delay_in;
   logic [BW-1:0] poll_ff, poll_in;
   logic          ack_ff, ack_in;
   logic          scl_ff, scl_in, sda_ff, sda_in, en_ff, en_in;
   logic          fail_ff, fail_in;
   logic [BW-1:0] rx_ff, rx_in;
   logic          done_in;
   logic [BW-1:0] dly_cfg_ff, tmo_cfg_ff;
   logic          rsp_vld_ff, rsp_vld_in;
   logic [15:0]   rsp_data_ff;
   logic          pop;

   assign pop_ready = !rsp_vld_ff || rsp_tready;
   assign pop       = pop_valid && pop_ready;
   assign bit_next  = bit_ff + 1'b1;

   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      delay_in = delay_ff;
      poll_in  = poll_ff;
      ack_in   = ack_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      en_in    = en_ff;
      fail_in  = fail_ff;
      rx_in    = rx_ff;
      done_in  = 1'b0;

      if (phase_ff == PH_IDLE) begin
         unique case (pop_tick.kind)
            i2cm_pkg::KIND_START: begin
               {scl_in, sda_in, en_in} = 3'b111;
               phase_in = PH_ST_A;
               delay_in = dly_cfg_ff;
            end
            i2cm_pkg::KIND_STOP: begin
               {scl_in, sda_in, en_in} = 3'b001;
               phase_in = PH_SP_A;
               delay_in = BW'(1);
            end
            i2cm_pkg::KIND_WRITE: begin
               fail_in  = 1'b0;
               bit_in   = '0;
               {scl_in, sda_in, en_in} = {1'b0, pop_tick.tx_byte[BW-1], 1'b1};
               shift_in = {pop_tick.tx_byte[BW-2:0], 1'b0};
               phase_in = PH_WR_LOW;
               delay_in = dly_cfg_ff;
            end
            i2cm_pkg::KIND_READ: begin
               scl_in   = 1'b0;
               en_in    = 1'b0;
               bit_in   = '0;
               shift_in = '0;
               ack_in   = pop_tick.send_ack;
               phase_in = PH_RD_LOW;
               delay_in = dly_cfg_ff;
            end
            default: begin
            end
         endcase
      end else if (phase_ff == PH_ACK_POLL) begin
         priority if (!pop_tick.sda_in) begin
            scl_in   = 1'b0;
            fail_in  = 1'b0;
            phase_in = PH_IDLE;
            done_in  = 1'b1;
         end else if (poll_ff >= tmo_cfg_ff) begin
            // no acknowledge: flag it and release the bus with a stop
            fail_in  = 1'b1;
            {scl_in, sda_in, en_in} = 3'b001;
            phase_in = PH_SP_A;
            delay_in = BW'(1);
         end else begin
            poll_in = poll_ff + 1'b1;
         end
      end else if (delay_ff > BW'(1)) begin
         delay_in = delay_ff - 1'b1;
      end else begin
         unique case (phase_ff)
            PH_ST_A: begin
               {scl_in, sda_in, en_in} = 3'b101;
               phase_in = PH_ST_B;
               delay_in = dly_cfg_ff;
            end
            PH_ST_B: begin
               scl_in   = 1'b0;
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
            PH_SP_A: begin
               {scl_in, sda_in, en_in} = 3'b101;
               phase_in = PH_SP_B;
               delay_in = dly_cfg_ff;
            end
            PH_SP_B: begin
               {scl_in, sda_in, en_in} = 3'b111;
               phase_in = PH_SP_C;
               delay_in = dly_cfg_ff;
            end
            PH_SP_C: begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
            PH_WR_LOW: begin
               scl_in   = 1'b1;
               phase_in = PH_WR_HIGH;
               delay_in = dly_cfg_ff;
            end
            PH_WR_HIGH: begin
               scl_in   = 1'b0;
               phase_in = PH_WR_TAIL;
               delay_in = dly_cfg_ff;
            end
            PH_WR_TAIL: begin
               bit_in = bit_next;
               if (bit_next < 4'd8) begin
                  {scl_in, sda_in, en_in} = {1'b0, shift_ff[BW-1], 1'b1};
                  shift_in = {shift_ff[BW-2:0], 1'b0};
                  phase_in = PH_WR_LOW;
               end else begin
                  {scl_in, sda_in, en_in} = 3'b011;
                  phase_in = PH_ACK_REL;
               end
               delay_in = dly_cfg_ff;
            end
            PH_ACK_REL: begin
               {scl_in, sda_in, en_in} = 3'b110;
               phase_in = PH_ACK_HIGH;
               delay_in = dly_cfg_ff;
            end
            PH_ACK_HIGH: begin
               poll_in  = '0;
               phase_in = PH_ACK_POLL;
            end
            PH_RD_LOW: begin
               // read bit sampled on the tick SCL rises
               scl_in   = 1'b1;
               shift_in = {shift_ff[BW-2:0], pop_tick.sda_in};
               phase_in = PH_RD_HIGH;
               delay_in = dly_cfg_ff;
            end
            PH_RD_HIGH: begin
               bit_in = bit_next;
               if (bit_next < 4'd8) begin
                  scl_in   = 1'b0;
                  phase_in = PH_RD_LOW;
               end else begin
                  rx_in    = shift_ff;
                  {scl_in, sda_in, en_in} = {1'b0, !ack_ff, 1'b1};
                  phase_in = PH_MA_SET;
               end
               delay_in = dly_cfg_ff;
            end
            PH_MA_SET: begin
               scl_in   = 1'b1;
               phase_in = PH_MA_CLK;
               delay_in = dly_cfg_ff;
            end
            PH_MA_CLK: begin
               scl_in   = 1'b0;
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
            PH_IDLE, PH_ACK_POLL: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_vld_in = pop ? 1'b1 : (rsp_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_ff     <= '0;
         shift_ff   <= '0;
         delay_ff   <= '0;
         poll_ff    <= '0;
         ack_ff     <= 1'b0;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
         en_ff      <= 1'b1;
         fail_ff    <= 1'b0;
         rx_ff      <= '0;
         rsp_vld_ff <= 1'b0;
         dly_cfg_ff <= i2cm_pkg::DELAY_TICKS_RST;
         tmo_cfg_ff <= i2cm_pkg::ACK_TIMEOUT_RST;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         if (pop) begin
            phase_ff <= phase_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            delay_ff <= delay_in;
            poll_ff  <= poll_in;
            ack_ff   <= ack_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            en_ff    <= en_in;
            fail_ff  <= fail_in;
            rx_ff    <= rx_in;
         end
         if (csr_valid) begin
            unique case (csr_index)
               i2cm_pkg::CSR_DELAY_TICKS: dly_cfg_ff <= csr_data;
               i2cm_pkg::CSR_ACK_TIMEOUT: tmo_cfg_ff <= csr_data;
            endcase
         end
      end
      if (pop) begin
         // fields from bit 0: scl, sda, sda_en, busy, done, rx_byte, ack_failed
         rsp_data_ff <= {2'b00, fail_in, rx_in, done_in, phase_in != PH_IDLE,
                         en_in, sda_in, scl_in};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   `I2CM_ASSERT_NEXT(a_done_to_idle, clock, reset, pop && done_in,
      phase_ff == PH_IDLE, "command completed but sequencer not idle")
   `I2CM_ASSERT_NOW(a_poll_released, clock, reset, phase_ff == PH_ACK_POLL,
      !en_ff && scl_ff, "ack poll with SDA driven or SCL low")
   `I2CM_ASSERT_NEXT(a_pop_loads_rsp, clock, reset, pop,
      rsp_vld_ff, "tick consumed without a result")

endmodule

`default_nettype wire

// File: rtl/core/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C bus master: start, stop, byte write with ack check, byte read.
// ----------------------------------------------------------------------------
// Every request transfer is one bus tick and yields exactly one response
// transfer with the line levels and status after that tick. A new tick is
// taken every clock cycle while the response side keeps up; a tick passes
// the front register, the queue and the sequencer result register on its
// way from request to response. Commands are honored only when the sequencer
// is idle. Line-settling waits last delay_ticks ticks (csr index 0) and the
// ack check fails on high sample ack_timeout+1 of SDA (csr index 1); write
// these only while no tick is in flight. csr_ready is always high.
`default_nettype none

module i2c_master_byte_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // tx_byte[7:0], send_ack[8], sda_in[9]
   input  wire logic [2:0]  req_tuser,   // cmd[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // scl_level[0], sda_level[1], sda_drive_en[2], busy_res[3], done_res[4],
   // rx_byte[12:5], ack_failed[13]
   output logic [15:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);

   logic               push_valid, push_ready, pop_valid, pop_ready;
   i2cm_pkg::tick_type push_tick, pop_tick;

   assign csr_ready = 1'b1;

   i2cm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_cmd      (req_tuser),
      .req_tx_byte  (req_tdata[7:0]),
      .req_send_ack (req_tdata[8]),
      .req_sda_in   (req_tdata[9]),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_tick    (push_tick)
   );

   i2cm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_tick  (push_tick),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_tick   (pop_tick)
   );

   i2cm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_tick   (pop_tick),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: tb/tb_i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine
// Self-checking bench for the I2C master byte engine.
// ----------------------------------------------------------------------------
// Ticks are queued as bus frames (start, address write, reads/writes, stop),
// a few lacking their start or stop. The sda_in levels are chosen per write
// so that acks arrive at once, arrive late or time out. A cycle model of the
// line sequencer predicts the status after every accepted tick; the monitor
// checks each response against it field by field. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine;

   localparam logic [i2cm_pkg::CMD_W-1:0] CMD_RSVD_LO = 3'd5;
   localparam logic [i2cm_pkg::CMD_W-1:0] CMD_RSVD_HI = 3'd7;

   typedef enum logic [4:0] {
      S_IDLE, S_START_A, S_START_B, S_STOP_A, S_STOP_B, S_STOP_C,
      S_WR_LOW, S_WR_HIGH, S_WR_TAIL, S_ACK_REL, S_ACK_HIGH, S_ACK_POLL,
      S_RD_LOW, S_RD_HIGH, S_MACK_SET, S_MACK_CLK
   } seq_phase_type;

   // same layout as rsp_tdata, lowest bit last
   typedef struct packed {
      logic [1:0] pad;
      logic       ack_failed;
      logic [7:0] rx_byte;
      logic       done;
      logic       busy;
      logic       sda_en;
      logic       sda_level;
      logic       scl_level;
   } bus_status_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] tx;
      logic       sack;
      logic       sda;
   } tick_item_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;   // tx_byte[7:0], send_ack[8], sda_in[9]
   logic [2:0]  req_tuser   = '0;   // cmd[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // scl_level[0], sda_level[1], sda_drive_en[2], busy_res[3], done_res[4],
   // rx_byte[12:5], ack_failed[13]
   logic [15:0] rsp_tdata;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic        csr_index   = 1'b0;
   logic [7:0]  csr_data    = '0;

   i2c_master_byte_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tick_item_type  tick_queue[$];
   bus_status_type expected_status[$];
   int             mismatches    = 0;
   int             send_idle_pct = 28;
   int             recv_idle_pct = 58;
   int             ticks_queued  = 0;

   // sequencer model state and its copy of the registers
   seq_phase_type m_phase;
   logic [3:0]    m_bits;
   logic [7:0]    m_shift, m_wait, m_polls, m_rx;
   logic          m_ack_sel, m_scl, m_sda, m_en, m_fail;
   logic [7:0]    cfg_delay, cfg_timeout;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void arm_wait(seq_phase_type nxt);
      m_phase = nxt;
      m_wait  = cfg_delay;
   endfunction

   function automatic void enter_stop();
      {m_scl, m_sda, m_en} = 3'b001;
      m_phase = S_STOP_A;
      m_wait  = 8'd1;
   endfunction

   function automatic void shift_out_bit();
      {m_scl, m_sda, m_en} = {1'b0, m_shift[7], 1'b1};
      m_shift = m_shift << 1;
      arm_wait(S_WR_LOW);
   endfunction

   function automatic bus_status_type advance_tick(logic [2:0] cmd, logic [7:0] tx,
                                                   logic sack, logic sda_in);
      bus_status_type st;
      logic           done;
      done = 1'b0;
      if (m_phase == S_IDLE) begin
         if (cmd == i2cm_pkg::CMD_START) begin
            {m_scl, m_sda, m_en} = 3'b111;
            arm_wait(S_START_A);
         end else if (cmd == i2cm_pkg::CMD_STOP) begin
            enter_stop();
         end else if (cmd == i2cm_pkg::CMD_WRITE) begin
            m_fail  = 1'b0;
            m_bits  = '0;
            m_shift = tx;
            shift_out_bit();
         end else if (cmd == i2cm_pkg::CMD_READ) begin
            // SDA released, its level register keeps the last driven value
            {m_scl, m_en} = 2'b00;
            m_bits    = '0;
            m_shift   = '0;
            m_ack_sel = sack;
            arm_wait(S_RD_LOW);
         end
      end else if (m_phase == S_ACK_POLL) begin
         if (!sda_in) begin
            m_scl   = 1'b0;
            m_fail  = 1'b0;
            m_phase = S_IDLE;
            done    = 1'b1;
         end else if (m_polls >= cfg_timeout) begin
            m_fail = 1'b1;
            enter_stop();
         end else begin
            m_polls = m_polls + 8'd1;
         end
      end else if (m_wait > 8'd1) begin
         m_wait = m_wait - 8'd1;
      end else begin
         case (m_phase)
            S_START_A: begin
               {m_scl, m_sda, m_en} = 3'b101;
               arm_wait(S_START_B);
            end
            S_START_B: begin
               m_scl   = 1'b0;
               m_phase = S_IDLE;
               done    = 1'b1;
            end
            S_STOP_A: begin
               {m_scl, m_sda, m_en} = 3'b101;
               arm_wait(S_STOP_B);
            end
            S_STOP_B: begin
               {m_scl, m_sda, m_en} = 3'b111;
               arm_wait(S_STOP_C);
            end
            S_STOP_C: begin
               m_phase = S_IDLE;
               done    = 1'b1;
            end
            S_WR_LOW: begin
               m_scl = 1'b1;
               arm_wait(S_WR_HIGH);
            end
            S_WR_HIGH: begin
               m_scl = 1'b0;
               arm_wait(S_WR_TAIL);
            end
            S_WR_TAIL: begin
               m_bits = m_bits + 4'd1;
               if (m_bits < 4'd8) begin
                  shift_out_bit();
               end else begin
                  {m_scl, m_sda, m_en} = 3'b011;
                  arm_wait(S_ACK_REL);
               end
            end
            S_ACK_REL: begin
               {m_scl, m_sda, m_en} = 3'b110;
               arm_wait(S_ACK_HIGH);
            end
            S_ACK_HIGH: begin
               m_polls = '0;
               m_phase = S_ACK_POLL;
            end
            S_RD_LOW: begin
               // bit is sampled on the tick SCL goes high
               m_scl   = 1'b1;
               m_shift = {m_shift[6:0], sda_in};
               arm_wait(S_RD_HIGH);
            end
            S_RD_HIGH: begin
               m_bits = m_bits + 4'd1;
               if (m_bits < 4'd8) begin
                  m_scl = 1'b0;
                  arm_wait(S_RD_LOW);
               end else begin
                  m_rx = m_shift;
                  {m_scl, m_sda, m_en} = {1'b0, ~m_ack_sel, 1'b1};
                  arm_wait(S_MACK_SET);
               end
            end
            S_MACK_SET: begin
               m_scl = 1'b1;
               arm_wait(S_MACK_CLK);
            end
            S_MACK_CLK: begin
               m_scl   = 1'b0;
               m_phase = S_IDLE;
               done    = 1'b1;
            end
            default: m_phase = S_IDLE;
         endcase
      end
      st.pad        = '0;
      st.ack_failed = m_fail;
      st.rx_byte    = m_rx;
      st.done       = done;
      st.busy       = (m_phase != S_IDLE);
      st.sda_en     = m_en;
      st.sda_level  = m_sda;
      st.scl_level  = m_scl;
      return st;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // request driver; the model advances on every accepted tick
   always @(posedge clock) begin : req_driver
      tick_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_status.push_back(advance_tick(req_tuser, req_tdata[7:0],
                                                   req_tdata[8], req_tdata[9]));
         if (!req_tvalid || req_tready) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               it = tick_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= it.cmd;
               req_tdata  <= {6'd0, it.sda, it.sack, it.tx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      bus_status_type want, got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = bus_status_type'(rsp_tdata);
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected response transfer, expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_status.pop_front();
               check_field("scl_level",    want.scl_level,  got.scl_level);
               check_field("sda_level",    want.sda_level,  got.sda_level);
               check_field("sda_drive_en", want.sda_en,     got.sda_en);
               check_field("busy_res",     want.busy,       got.busy);
               check_field("done_res",     want.done,       got.done);
               check_field("rx_byte",      want.rx_byte,    got.rx_byte);
               check_field("ack_failed",   want.ack_failed, got.ack_failed);
               check_field("padding",      want.pad,        got.pad);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic push_tick(input logic [2:0] cmd, input logic [7:0] tx,
                            input logic sack, input logic sda);
      tick_item_type it;
      it.cmd  = cmd;
      it.tx   = tx;
      it.sack = sack;
      it.sda  = sda;
      tick_queue.push_back(it);
      ticks_queued++;
   endtask

   // tick while the sequencer is busy: any command on it is ignored
   task automatic push_busy_tick(input logic sda);
      logic [2:0] cmd;
      cmd = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : i2cm_pkg::CMD_NONE;
      push_tick(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)), sda);
   endtask

   // one command plus the ticks that carry it to completion.
   // ack_mode: 0 ack at once, 1 ack after a few high polls, 2 timeout.
   // sda_fill: level of sda_in while busy, negative for random.
   task automatic issue_command(input logic [2:0] cmd, input logic [7:0] tx,
                                input logic sack, input int ack_mode, input int sda_fill);
      int   w, busy_len, highs;
      logic sda;
      w = (cfg_delay == 0) ? 1 : int'(cfg_delay);
      busy_len = 0;
      highs = 0;
      push_tick(cmd, tx, sack, 1'($urandom_range(1)));
      case (cmd)
         i2cm_pkg::CMD_START: busy_len = 2 * w;
         i2cm_pkg::CMD_STOP:  busy_len = 2 * w + 1;
         i2cm_pkg::CMD_WRITE: busy_len = 26 * w;
         i2cm_pkg::CMD_READ:  busy_len = 18 * w;
         default:             busy_len = 0;
      endcase
      repeat (busy_len) begin
         sda = (sda_fill < 0) ? 1'($urandom_range(1)) : 1'(sda_fill);
         push_busy_tick(sda);
      end
      if (cmd == i2cm_pkg::CMD_WRITE) begin
         if (ack_mode == 1 && cfg_timeout != 0)
            highs = $urandom_range(1, (cfg_timeout < 6) ? int'(cfg_timeout) : 6);
         else if (ack_mode == 2)
            highs = int'(cfg_timeout) + 1;
         repeat (highs) push_busy_tick(1'b1);
         if (ack_mode == 2) begin
            repeat (2 * w + 1) push_busy_tick(1'($urandom_range(1)));
         end else begin
            push_busy_tick(1'b0);
         end
      end
      // idle slack; reserved codes here are ignored like none
      repeat ($urandom_range(0, 2))
         push_tick(($urandom_range(3) == 0) ? 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI))
                                            : i2cm_pkg::CMD_NONE,
                   8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // every queued tick accepted and every response transfer seen
   task automatic settle();
      do @(posedge clock);
      while (tick_queue.size() != 0 || req_tvalid || expected_status.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // register writes are safe only with the sequencer idle
   task automatic drain_to_idle();
      settle();
      while (m_phase != S_IDLE) begin
         repeat (32) push_tick(i2cm_pkg::CMD_NONE, 8'd0, 1'b0, 1'b0);
         settle();
      end
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == i2cm_pkg::CSR_DELAY_TICKS) cfg_delay = val;
      else cfg_timeout = val;
   endtask

   initial begin : stimulus
      int start_count, n_ops;
      logic broken;
      m_phase     = S_IDLE;
      m_bits      = '0;
      m_shift     = '0;
      m_wait      = '0;
      m_polls     = '0;
      m_rx        = '0;
      m_ack_sel   = 1'b0;
      {m_scl, m_sda, m_en} = 3'b111;
      m_fail      = 1'b0;
      cfg_delay   = i2cm_pkg::DELAY_TICKS_RST;
      cfg_timeout = i2cm_pkg::ACK_TIMEOUT_RST;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // register reset values
      issue_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, 0, -1);
      drain_to_idle();

      // zero delay: one-tick waits; zero timeout: first high poll fails
      write_reg(i2cm_pkg::CSR_DELAY_TICKS, 8'd0);
      write_reg(i2cm_pkg::CSR_ACK_TIMEOUT, 8'd0);
      push_tick(CMD_RSVD_LO, 8'hFF, 1'b1, 1'b1);
      push_tick(CMD_RSVD_HI, 8'h00, 1'b0, 1'b0);
      issue_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, 0, -1);
      issue_command(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1, 0, 1);
      issue_command(i2cm_pkg::CMD_WRITE, 8'h00, 1'b0, 2, 0);
      issue_command(i2cm_pkg::CMD_READ,  8'h00, 1'b1, 0, 1);
      issue_command(i2cm_pkg::CMD_READ,  8'hFF, 1'b0, 0, 0);
      issue_command(i2cm_pkg::CMD_STOP,  8'h00, 1'b0, 0, -1);
      drain_to_idle();

      // longest waits and longest ack poll
      write_reg(i2cm_pkg::CSR_DELAY_TICKS, 8'd255);
      issue_command(i2cm_pkg::CMD_START, 8'h5A, 1'b1, 0, -1);
      drain_to_idle();
      write_reg(i2cm_pkg::CSR_DELAY_TICKS, 8'd1);
      write_reg(i2cm_pkg::CSR_ACK_TIMEOUT, 8'd255);
      issue_command(i2cm_pkg::CMD_WRITE, 8'hC3, 1'b0, 2, -1);
      issue_command(i2cm_pkg::CMD_WRITE, 8'h3C, 1'b1, 1, -1);
      drain_to_idle();

      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 28 : (p == 1) ? 58 : 0;
         recv_idle_pct = (p == 0) ? 58 : (p == 1) ? 28 : 0;
         write_reg(i2cm_pkg::CSR_DELAY_TICKS, ($urandom_range(5) == 0) ? 8'd0
                                                        : 8'($urandom_range(1, 3)));
         write_reg(i2cm_pkg::CSR_ACK_TIMEOUT, ($urandom_range(3) == 0)
                                                 ? 8'($urandom_range(9, 255))
                                                 : 8'($urandom_range(0, 8)));
         start_count = ticks_queued;
         while (ticks_queued - start_count < 120) begin
            // mostly whole frames; a few lack their start or stop
            broken = ($urandom_range(9) == 0);
            if (!broken || $urandom_range(1))
               issue_command(i2cm_pkg::CMD_START, 8'($urandom_range(255)),
                             1'($urandom_range(1)), 0, -1);
            issue_command(i2cm_pkg::CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          ($urandom_range(3) == 0) ? 2 : $urandom_range(1), -1);
            n_ops = $urandom_range(1, 3);
            repeat (n_ops) begin
               if ($urandom_range(1))
                  issue_command(i2cm_pkg::CMD_WRITE, 8'($urandom_range(255)),
                                1'($urandom_range(1)),
                                ($urandom_range(3) == 0) ? 2 : $urandom_range(1), -1);
               else
                  issue_command(i2cm_pkg::CMD_READ, 8'($urandom_range(255)),
                                1'($urandom_range(1)), 0, -1);
            end
            if (!broken || $urandom_range(1))
               issue_command(i2cm_pkg::CMD_STOP, 8'($urandom_range(255)),
                             1'($urandom_range(1)), 0, -1);
         end
         drain_to_idle();
      end

      settle();
      if (mismatches == 0 && expected_status.size() == 0)
         $display("i2c_master_byte_engine test passed");
      else
         $display("i2c_master_byte_engine test failed");
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("i2c_master_byte_engine test failed");
      $finish;
   end

endmodule

// File: i2c_master_byte_engine.f
+incdir+rtl/core
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_queue.sv
rtl/core/i2cm_seq.sv
rtl/core/i2c_master_byte_engine.sv
tb/tb_i2c_master_byte_engine.sv
